[rtl/apiir_pkg.sv]
package apiir_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 24;
  localparam int unsigned FracBits = 20;
  localparam int unsigned MaxOrder = 6;
  localparam int unsigned OrderW   = 3;
  localparam int unsigned PtrW     = 3;
  localparam int unsigned ProdW    = CoefW + SampleW;
  // gain term plus up to six taps, one guard bit each way
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned YWideW   = AccW - FracBits;

  localparam logic [CoefW-1:0] GainReset = CoefW'(1048576);

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegGain  = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] RegOrder = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] RegCoef1 = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] RegCoef6 = CfgAddrW'(7);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

endpackage

[rtl/all_pole_iir_filter.sv]
// all-pole iir filter: y = gain*x - sum(k=1..order) coef_k * y[n-k]
//
// input stream (s_axis_*): one signed 16-bit sample per transaction.
// output stream (m_axis_*): one filtered sample per input sample, with
// tuser flagging that the result was clipped to the 16-bit range.
// config port (cfg_*): index 0 gain, 1 filter order (7 acts as 6),
// 2..7 coef_1..coef_6, all Q4.20; cfg_ready_o is always high, unknown
// indexes are dropped. write only while no sample is in flight.
//
// one shared 24x16 multiplier walks the gain term and then each tap, one
// product per cycle, with a register between multiplier and accumulator.
// after acceptance a sample runs order+1 multiplies, then a drain step for
// the last product, then a finish step that rounds, saturates and loads
// the output register. input is not ready meanwhile, so a new sample is
// taken only once the last one has left the finish step.
//
// the output register frees the datapath, so a new sample is accepted
// while a result waits; if the receiver stalls, the next result holds in
// the finish step until the output register is taken.
// reset: gain 1.0, order 0, coefficients and past outputs zero.
module all_pole_iir_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apiir_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [apiir_pkg::CoefW-1:0]     cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [apiir_pkg::SampleW-1:0]   s_axis_tdata,   // [15:0] sample_in
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [apiir_pkg::SampleW-1:0]   m_axis_tdata,   // [15:0] sample_out
  output logic                            m_axis_tuser    // [0] saturated
);
  import apiir_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain,
    StFinish
  } state_e;

  // configuration registers
  coef_t             gain_q;
  logic [OrderW-1:0] order_q;
  coef_t             coef_q [MaxOrder];

  // past outputs, circular
  sample_t           past_q [MaxOrder];
  logic [PtrW-1:0]   newest_q;

  // sequencer and datapath
  state_e                  state_q;
  logic [OrderW-1:0]       step_q;
  logic [OrderW-1:0]       taps_q;
  logic [PtrW-1:0]         rd_ptr_q;
  sample_t                 x_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic                    prod_sub_q;
  logic signed [AccW-1:0]  acc_q;

  // output register
  logic    out_vld_q;
  sample_t out_data_q;
  logic    out_sat_q;

  logic                     s_accept;
  logic                     out_free;
  logic [OrderW-1:0]        taps_d;
  logic [PtrW-1:0]          coef_idx;
  logic [PtrW-1:0]          rd_ptr_inc;
  logic [PtrW-1:0]          newest_dec;
  coef_t                    mul_a;
  sample_t                  mul_b;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [AccW-1:0]   acc_add;
  logic signed [AccW-1:0]   round_sum;
  logic signed [YWideW-1:0] y_wide;
  sample_t                  y_sat;
  logic                     y_clip;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // order above the store depth saturates
  assign taps_d = (order_q > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : order_q;

  assign coef_idx   = step_q - PtrW'(1);
  assign rd_ptr_inc = (rd_ptr_q == PtrW'(MaxOrder - 1)) ? '0 : rd_ptr_q + PtrW'(1);
  assign newest_dec = (newest_q == '0) ? PtrW'(MaxOrder - 1) : newest_q - PtrW'(1);

  // shared multiplier: gain*x on step zero, then coef_k * y[n-k]
  always_comb begin
    if (step_q == '0) begin
      mul_a = gain_q;
      mul_b = x_q;
    end else begin
      mul_a = coef_q[coef_idx];
      mul_b = past_q[rd_ptr_q];
    end
  end
  assign prod_d = mul_a * mul_b;

  // accumulate: feedback taps subtract
  always_comb begin
    if (!prod_vld_q) begin
      acc_add = acc_q;
    end else if (prod_sub_q) begin
      acc_add = acc_q - AccW'(prod_q);
    end else begin
      acc_add = acc_q + AccW'(prod_q);
    end
  end

  // round to nearest, ties up, then clip to the sample range
  assign round_sum = acc_q + AccW'(1 << (FracBits - 1));
  assign y_wide    = round_sum[AccW-1:FracBits];
  always_comb begin
    if (y_wide > YWideW'(signed'({1'b0, {(SampleW-1){1'b1}}}))) begin
      y_sat  = {1'b0, {(SampleW-1){1'b1}}};
      y_clip = 1'b1;
    end else if (y_wide < YWideW'(signed'({1'b1, {(SampleW-1){1'b0}}}))) begin
      y_sat  = {1'b1, {(SampleW-1){1'b0}}};
      y_clip = 1'b1;
    end else begin
      y_sat  = y_wide[SampleW-1:0];
      y_clip = 1'b0;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainReset;
      order_q <= '0;
      for (int i = 0; i < MaxOrder; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == RegGain) begin
        gain_q <= cfg_data_i;
      end else if (cfg_addr_i == RegOrder) begin
        order_q <= cfg_data_i[OrderW-1:0];
      end else if (cfg_addr_i >= RegCoef1 && cfg_addr_i <= RegCoef6) begin
        coef_q[PtrW'(cfg_addr_i - RegCoef1)] <= cfg_data_i;
      end
    end
  end

  // past-output store, written when a result is finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      for (int i = 0; i < MaxOrder; i++) begin
        past_q[i] <= '0;
      end
    end else if (state_q == StFinish && out_free) begin
      newest_q           <= newest_dec;
      past_q[newest_dec] <= y_sat;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_q     <= '0;
      taps_q     <= '0;
      rd_ptr_q   <= '0;
      x_q        <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_sat_q  <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_vld_q && m_axis_tready && state_q != StFinish) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_accept) begin
            x_q        <= s_axis_tdata;
            step_q     <= '0;
            taps_q     <= taps_d;
            rd_ptr_q   <= newest_q;
            acc_q      <= '0;
            prod_vld_q <= 1'b0;
            state_q    <= StMac;
          end
        end
        StMac: begin
          prod_q     <= prod_d;
          prod_sub_q <= (step_q != '0);
          prod_vld_q <= 1'b1;
          acc_q      <= acc_add;
          if (step_q != '0) begin
            rd_ptr_q <= rd_ptr_inc;
          end
          if (step_q == taps_q) begin
            state_q <= StDrain;
          end else begin
            step_q <= step_q + OrderW'(1);
          end
        end
        StDrain: begin
          acc_q      <= acc_add;
          prod_vld_q <= 1'b0;
          state_q    <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= y_sat;
            out_sat_q  <= y_clip;
            state_q    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // the circular pointers never leave the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    newest_q < PtrW'(MaxOrder) && rd_ptr_q < PtrW'(MaxOrder))
    else $error("past-output pointer out of range");

  // the tap walk never runs past the tap count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMac |-> step_q <= taps_q && taps_q <= OrderW'(MaxOrder))
    else $error("tap step beyond tap count");

  // a clipped result sits exactly at a range end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == {1'b0, {(SampleW-1){1'b1}}} ||
      m_axis_tdata == {1'b1, {(SampleW-1){1'b0}}})
    else $error("saturation flag without clipped value");

  // an accepted sample blocks the input at the start of its computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input ready during computation");

endmodule
